/* rtl/dmx_pkg.sv */
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared constants, register indexes and the sample decoder of the PCM
// downmix block.
// ----------------------------------------------------------------------------
package dmx_pkg;

  localparam int unsigned DefMaxChannels = 8;
  localparam int unsigned DefQueueDepth = 4;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned BpsW     = 7;
  localparam int unsigned ChanCfgW = 4;
  localparam int unsigned SampleW  = 32;

  localparam logic [CfgIdxW-1:0] CFG_BITS_PER_SAMPLE = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_COUNT   = 8'd1;

  localparam logic [BpsW-1:0]     BPS_RESET  = 7'd16;
  localparam logic [ChanCfgW-1:0] CHAN_RESET = 4'd2;

  localparam logic [BpsW-1:0] DEPTH_8  = 7'd8;
  localparam logic [BpsW-1:0] DEPTH_16 = 7'd16;
  localparam logic [BpsW-1:0] DEPTH_24 = 7'd24;
  localparam logic [BpsW-1:0] DEPTH_32 = 7'd32;

  // Map the low four bytes of a sample to signed Q0.31.
  function automatic logic signed [SampleW-1:0] decode_sample(
    input logic [BpsW-1:0]    bps,
    input logic [SampleW-1:0] raw
  );
    logic [SampleW-1:0] q;
    q = '0;
    case (bps)
      DEPTH_8:  q = {raw[7] ^ 1'b1, raw[6:0], 24'd0};
      DEPTH_16: q = {raw[15:0], 16'd0};
      DEPTH_24: q = {raw[23:0], 8'd0};
      DEPTH_32: q = raw;
      default:  q = '0;
    endcase
    return signed'(q);
  endfunction

endpackage

/* rtl/pcm_frame_downmix.sv */
// ----------------------------------------------------------------------------
// pcm_frame_downmix
// Interleaved PCM byte stream to mono downmix.
//
// Input channel: one data byte per transfer (push_i while full_o is low),
// least significant byte of each sample first. Bytes are taken every cycle
// while the frame queue has room.
// Output channel: one mono Q0.31 sample per complete frame, shown while
// empty_o is low and taken with pop_i.
// Configuration channel: cfg_valid_i/cfg_ready_o, always ready; index 0 is
// bits_per_sample, index 1 is channel_count. Write only while idle;
// a write to either register restarts frame assembly.
// Each frame sum passes through the queue to the bit-serial divider, which
// works through its SUM_W bits (SUM_W is 35 at eight channels).
// Throughput: one byte per cycle while full_o is low; the divider takes one
// frame at a time, so short frames back up into the queue and raise full_o.
// Reset: 16 bits per sample, two channels, queue and output empty.
// While the receiver stalls the result holds, the divider and the queue
// fill, and full_o rises once the queue is full.
// ----------------------------------------------------------------------------
module pcm_frame_downmix import dmx_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = DefMaxChannels,
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic [7:0]                data_byte_i,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic signed [SampleW-1:0] mono_sample_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned SumW = SampleW + $clog2(MAX_CHANNELS);
  localparam int unsigned ChW  = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned QW   = SumW + ChW;

  logic                   f_valid, f_ready;
  logic signed [SumW-1:0] f_sum;
  logic [ChW-1:0]         f_chans;
  logic                   q_valid, q_ready;
  logic [QW-1:0]          q_data;

  assign cfg_ready_o = 1'b1;

  dmx_front #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .SUM_W(SumW),
    .CH_W(ChW)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .push_i,
    .data_byte_i,
    .full_o,
    .frame_valid_o(f_valid),
    .frame_ready_i(f_ready),
    .frame_sum_o(f_sum),
    .frame_chans_o(f_chans)
  );

  dmx_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i({f_sum, f_chans}),
    .rd_valid_o(q_valid),
    .rd_ready_i(q_ready),
    .rd_data_o(q_data)
  );

  dmx_back #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .SUM_W(SumW),
    .CH_W(ChW)
  ) u_back (
    .clk_i,
    .rst_ni,
    .frame_valid_i(q_valid),
    .frame_ready_o(q_ready),
    .frame_sum_i(signed'(q_data[QW-1:ChW])),
    .frame_chans_i(q_data[ChW-1:0]),
    .empty_o,
    .pop_i,
    .mono_sample_o
  );

endmodule

/* rtl/dmx_queue.sv */
// ----------------------------------------------------------------------------
// dmx_queue
// Short first-in first-out queue carrying finished frame sums from the
// byte front end to the divider.
// ----------------------------------------------------------------------------
module dmx_queue import dmx_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = DefQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (count_q != FullCnt);
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_ready_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* rtl/dmx_front.sv */
// ----------------------------------------------------------------------------
// dmx_front
// Holds the configuration registers, takes raw bytes, assembles and decodes
// samples and accumulates the frame sum; emits one sum per complete frame.
// ----------------------------------------------------------------------------
module dmx_front import dmx_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = DefMaxChannels,
  parameter int unsigned SUM_W = SampleW + $clog2(MAX_CHANNELS),
  parameter int unsigned CH_W = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  input  logic                    push_i,
  input  logic [7:0]              data_byte_i,
  output logic                    full_o,
  output logic                    frame_valid_o,
  input  logic                    frame_ready_i,
  output logic signed [SUM_W-1:0] frame_sum_o,
  output logic [CH_W-1:0]         frame_chans_o
);

  logic [BpsW-1:0]         bps_q;
  logic [ChanCfgW-1:0]     chan_cfg_q;
  logic [2:0]              byte_pos_q;
  logic [CH_W-1:0]         chan_pos_q;
  logic [SampleW-1:0]      asm_q, asm_next;
  logic signed [SUM_W-1:0] sum_q, sum_next;
  logic signed [SampleW-1:0] dec;
  logic [3:0]              stride;
  logic [CH_W-1:0]         chans_used;
  logic                    accept, last_byte, last_chan, cfg_hit;

  assign full_o = !frame_ready_i;
  assign accept = push_i && frame_ready_i;

  always_comb begin
    stride = bps_q[6:3];
    if (stride == 4'd0) begin
      stride = 4'd1;
    end else if (stride > 4'd8) begin
      stride = 4'd8;
    end
  end

  always_comb begin
    if (chan_cfg_q == '0) begin
      chans_used = CH_W'(1);
    end else if (32'(chan_cfg_q) > MAX_CHANNELS) begin
      chans_used = CH_W'(MAX_CHANNELS);
    end else begin
      chans_used = CH_W'(chan_cfg_q);
    end
  end

  always_comb begin
    asm_next = asm_q;
    if (!byte_pos_q[2]) begin
      case (byte_pos_q[1:0])
        2'd0:    asm_next[7:0]   = asm_q[7:0]   | data_byte_i;
        2'd1:    asm_next[15:8]  = asm_q[15:8]  | data_byte_i;
        2'd2:    asm_next[23:16] = asm_q[23:16] | data_byte_i;
        2'd3:    asm_next[31:24] = asm_q[31:24] | data_byte_i;
        default: asm_next = asm_q;
      endcase
    end
  end

  assign dec       = decode_sample(bps_q, asm_next);
  assign sum_next  = sum_q + SUM_W'(dec);
  assign last_byte = ({1'b0, byte_pos_q} + 4'd1) >= stride;
  assign last_chan = (chan_pos_q + 1'b1) >= chans_used;
  assign cfg_hit   = cfg_valid_i &&
                     (cfg_index_i == CFG_BITS_PER_SAMPLE ||
                      cfg_index_i == CFG_CHANNEL_COUNT);

  assign frame_valid_o = push_i && last_byte && last_chan;
  assign frame_sum_o   = sum_next;
  assign frame_chans_o = chans_used;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q      <= BPS_RESET;
      chan_cfg_q <= CHAN_RESET;
      byte_pos_q <= '0;
      chan_pos_q <= '0;
      asm_q      <= '0;
      sum_q      <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == CFG_BITS_PER_SAMPLE) begin
        bps_q <= cfg_data_i[BpsW-1:0];
      end else begin
        chan_cfg_q <= cfg_data_i[ChanCfgW-1:0];
      end
      byte_pos_q <= '0;
      chan_pos_q <= '0;
      asm_q      <= '0;
      sum_q      <= '0;
    end else if (accept) begin
      if (!last_byte) begin
        byte_pos_q <= byte_pos_q + 1'b1;
        asm_q      <= asm_next;
      end else begin
        byte_pos_q <= '0;
        asm_q      <= '0;
        if (last_chan) begin
          chan_pos_q <= '0;
          sum_q      <= '0;
        end else begin
          chan_pos_q <= chan_pos_q + 1'b1;
          sum_q      <= sum_next;
        end
      end
    end
  end

endmodule

/* rtl/dmx_back.sv */
// ----------------------------------------------------------------------------
// dmx_back
// Divides each frame sum by its channel count, one quotient bit per cycle,
// rounding toward zero, and holds the result in an output register.
// ----------------------------------------------------------------------------
module dmx_back import dmx_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = DefMaxChannels,
  parameter int unsigned SUM_W = SampleW + $clog2(MAX_CHANNELS),
  parameter int unsigned CH_W = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      frame_valid_i,
  output logic                      frame_ready_o,
  input  logic signed [SUM_W-1:0]   frame_sum_i,
  input  logic [CH_W-1:0]           frame_chans_i,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic signed [SampleW-1:0] mono_sample_o
);

  localparam int unsigned StepW = $clog2(SUM_W + 1);
  localparam logic [StepW-1:0] LastStep = StepW'(SUM_W - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_e;

  state_e              state_q, state_d;
  logic [SUM_W-1:0]    quo_q, quo_d;
  logic [CH_W-1:0]     rem_q, rem_d;
  logic [CH_W-1:0]     div_q, div_d;
  logic [StepW-1:0]    step_q, step_d;
  logic                neg_q, neg_d;
  logic                out_valid_q, out_valid_d;
  logic [SampleW-1:0]  out_q, out_d;
  logic [CH_W:0]       rem_sh, rem_sub;
  logic                ge;
  logic [SUM_W-1:0]    quo_signed;

  assign rem_sh     = {rem_q, quo_q[SUM_W-1]};
  assign ge         = rem_sh >= {1'b0, div_q};
  assign rem_sub    = rem_sh - {1'b0, div_q};
  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;

  assign frame_ready_o = (state_q == ST_IDLE);
  assign empty_o       = !out_valid_q;
  assign mono_sample_o = signed'(out_q);

  always_comb begin
    state_d     = state_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    div_d       = div_q;
    step_d      = step_q;
    neg_d       = neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (frame_valid_i) begin
          neg_d   = frame_sum_i[SUM_W-1];
          quo_d   = frame_sum_i[SUM_W-1] ? (~frame_sum_i + 1'b1) : frame_sum_i;
          rem_d   = '0;
          div_d   = frame_chans_i;
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_d = {quo_q[SUM_W-2:0], ge};
        rem_d = ge ? rem_sub[CH_W-1:0] : rem_sh[CH_W-1:0];
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || pop_i) begin
          out_d       = quo_signed[SampleW-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      neg_q       <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
      div_q       <= div_d;
      neg_q       <= neg_d;
      out_q       <= out_d;
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PCM frame downmix. Bytes are fed through the
// push/full side while a local model tracks the sample assembly and frame
// sum and queues the expected frame means; the pop side compares every
// transfer in order. Runs directed extremes, then many register settings
// with random bytes, random sender and receiver stalls, and a long receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import dmx_pkg::*;

  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned NumPlans    = 13;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 8'hFF;

  localparam logic [BpsW-1:0] DepthPlan [NumPlans] = '{
    7'd16, 7'd8, 7'd24, 7'd32, 7'd0, 7'd7, 7'd12, 7'd64, 7'd65, 7'd127, 7'd8, 7'd40, 7'd16
  };
  localparam logic [ChanCfgW-1:0] ChanPlan [NumPlans] = '{
    4'd2, 4'd1, 4'd3, 4'd8, 4'd0, 4'd1, 4'd15, 4'd2, 4'd1, 4'd9, 4'd4, 4'd3, 4'd5
  };

  typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;

  logic                      clk_i = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      push = 1'b0;
  logic                      pop = 1'b0;
  logic [7:0]                data_byte = '0;
  logic                      cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index = '0;
  logic [CfgDataW-1:0]       cfg_data = '0;
  logic                      full_o;
  logic                      empty_o;
  logic                      cfg_ready_o;
  logic signed [SampleW-1:0] mono_sample_o;

  logic [7:0]                byte_queue [$];
  logic signed [SampleW-1:0] mono_expect [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_count = 0;
  int unsigned bytes_in = 0;
  int unsigned frames_out = 0;
  int unsigned cfg_writes = 0;
  int unsigned full_stalls = 0;

  logic [BpsW-1:0]     depth_q;
  logic [ChanCfgW-1:0] chan_cfg_q;
  int unsigned         byte_idx;
  int unsigned         chan_idx;
  logic [31:0]         raw_word;
  longint              frame_acc;

  always #5 clk_i = ~clk_i;

  pcm_frame_downmix dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .push_i        (push),
    .full_o        (full_o),
    .data_byte_i   (data_byte),
    .empty_o       (empty_o),
    .pop_i         (pop),
    .mono_sample_o (mono_sample_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  function automatic int unsigned stride_of(logic [BpsW-1:0] bps);
    int unsigned s;
    s = bps >> 3;
    if (s < 1) s = 1;
    if (s > 8) s = 8;
    return s;
  endfunction

  function automatic int unsigned chans_of(logic [ChanCfgW-1:0] c);
    int unsigned n;
    n = c;
    if (n < 1) n = 1;
    if (n > DefMaxChannels) n = DefMaxChannels;
    return n;
  endfunction

  function automatic longint to_q31(logic [BpsW-1:0] bps, logic [31:0] raw);
    logic [31:0] q;
    case (bps)
      DEPTH_8:  q = {raw[7:0] ^ 8'h80, 24'h0};
      DEPTH_16: q = raw << 16;
      DEPTH_24: q = raw << 8;
      DEPTH_32: q = raw;
      default:  q = '0;
    endcase
    return longint'(signed'(q));
  endfunction

  function automatic void clear_frame();
    byte_idx = 0;
    chan_idx = 0;
    raw_word = '0;
    frame_acc = 0;
  endfunction

  function automatic bit frame_step(input logic [7:0] b, output logic signed [31:0] mean);
    longint avg;
    mean = '0;
    if (byte_idx < 4) raw_word |= 32'(b) << (8 * byte_idx);
    byte_idx++;
    if (byte_idx < stride_of(depth_q)) return 1'b0;
    frame_acc += to_q31(depth_q, raw_word);
    byte_idx = 0;
    raw_word = '0;
    chan_idx++;
    if (chan_idx < chans_of(chan_cfg_q)) return 1'b0;
    avg = frame_acc / longint'(chans_of(chan_cfg_q));
    mean = avg[31:0];
    chan_idx = 0;
    frame_acc = 0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: return 8'h00;
        1: return 8'h7F;
        2: return 8'h80;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void set_idle(idle_mode_e mode);
    tx_idle_pct  = (mode == IDLE_TX) ? 61 : (mode == IDLE_BOTH) ? 6 : 0;
    rx_stall_pct = (mode == IDLE_RX) ? 61 : (mode == IDLE_BOTH) ? 6 : 0;
  endfunction

  task automatic report(string what, logic signed [31:0] want, logic signed [31:0] got);
    err_count++;
    if (err_count <= 10)
      $display("[%0t] %s: expected %0d (0x%08h), got %0d (0x%08h)",
               $time, what, want, want, got, got);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BITS_PER_SAMPLE: begin
        depth_q = val[BpsW-1:0];
        clear_frame();
      end
      CFG_CHANNEL_COUNT: begin
        chan_cfg_q = val[ChanCfgW-1:0];
        clear_frame();
      end
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_random(int unsigned n);
    repeat (n) byte_queue.push_back(pick_byte());
  endtask

  task automatic settle();
    while (byte_queue.size() != 0 || mono_expect.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // byte side: take the transfer at the rising edge, offer at the falling edge
  always @(posedge clk_i) begin : take_byte
    logic signed [31:0] mean;
    if (push && !full_o) begin
      bytes_in++;
      if (frame_step(byte_queue.pop_front(), mean)) mono_expect.push_back(mean);
    end
    if (push && full_o) full_stalls++;
  end

  always @(negedge clk_i) begin
    if (rst_n && byte_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
      push      <= 1'b1;
      data_byte <= byte_queue[0];
    end else begin
      push <= 1'b0;
    end
  end

  // result side
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      pop <= 1'b0;
      rx_hold--;
    end else begin
      pop <= rst_n && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_mean
    logic signed [31:0] want;
    if (pop && !empty_o) begin
      frames_out++;
      if (mono_expect.size() == 0) begin
        report("mono sample with no frame pending", '0, mono_sample_o);
      end else begin
        want = mono_expect.pop_front();
        if (mono_sample_o !== want) report("mono_sample mismatch", want, mono_sample_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full_o) || (pop && !empty_o) || (cfg_valid && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("No transfer for %0d cycles, %0d frames still due", StallLimit,
               mono_expect.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n;
    depth_q    = BPS_RESET;
    chan_cfg_q = CHAN_RESET;
    clear_frame();
    set_idle(IDLE_NONE);
    repeat (2) @(negedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset setting: 16-bit stereo, full-scale negative and positive
    byte_queue = {8'h00, 8'h80, 8'hFF, 8'h7F};
    settle();
    write_reg(CFG_BITS_PER_SAMPLE, DEPTH_8);
    write_reg(CFG_CHANNEL_COUNT, 7'd1);
    byte_queue = {8'h00, 8'hFF, 8'h80, 8'h7F};
    settle();
    write_reg(CFG_BITS_PER_SAMPLE, DEPTH_32);
    write_reg(CFG_CHANNEL_COUNT, 7'd2);
    byte_queue = {8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
    settle();
    write_reg(CFG_BITS_PER_SAMPLE, DEPTH_24);
    write_reg(CFG_CHANNEL_COUNT, 7'd3);
    byte_queue = {8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF};
    settle();

    for (int unsigned p = 0; p < NumPlans; p++) begin
      set_idle(idle_mode_e'(p % 4));
      write_reg(CFG_BITS_PER_SAMPLE, DepthPlan[p]);
      write_reg(CFG_CHANNEL_COUNT, {3'($urandom), ChanPlan[p]});
      n = $urandom_range(40, 65);
      load_random(n / 2);
      // pause mid-frame and poke an unused index; the frame must carry on
      if (p % 2 == 1) begin
        settle();
        write_reg((p % 4 == 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 7'($urandom));
      end
      load_random(n - n / 2);
      settle();
    end

    // hold the receiver while short frames pour in until the block backs up
    set_idle(IDLE_NONE);
    write_reg(CFG_BITS_PER_SAMPLE, DEPTH_8);
    write_reg(CFG_CHANNEL_COUNT, 7'd1);
    rx_hold = LongHold;
    load_random(80);
    settle();

    $display("Covered %0d bytes, %0d frame means, %0d register writes over %0d settings",
             bytes_in, frames_out, cfg_writes, NumPlans + 5);
    $display("Input held off by full for %0d cycles; %0d mismatches", full_stalls, err_count);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
